// ===== design/bchd_pkg.sv =====
// Shared types and constants for the button click and hold detector.
package bchd_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned COUNT_W    = 16;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_ENABLED   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT_INPUT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PRESS       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP         = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_SPAN     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_INTERVAL   = 3'd6;

	// reset values
	localparam logic [CFG_DATA_W-1:0] RST_SAMPLE_INTERVAL = 16'd5;
	localparam logic [CFG_DATA_W-1:0] RST_MIN_PRESS       = 16'd40;
	localparam logic [CFG_DATA_W-1:0] RST_MIN_GAP         = 16'd40;
	localparam logic [CFG_DATA_W-1:0] RST_DOUBLE_SPAN     = 16'd500;
	localparam logic [CFG_DATA_W-1:0] RST_HOLD_INTERVAL   = 16'd500;

	typedef struct packed {
		logic                  block_enabled;
		logic                  invert_input;
		logic [CFG_DATA_W-1:0] sample_interval_ms;
		logic [CFG_DATA_W-1:0] min_press_ms;
		logic [CFG_DATA_W-1:0] min_gap_ms;
		logic [CFG_DATA_W-1:0] double_span_ms;
		logic [CFG_DATA_W-1:0] hold_interval_ms;
	} cfg_t;

	// packed from the top bit down, so click_total lands in the high bits
	typedef struct packed {
		logic [COUNT_W-1:0] click_total;
		logic               hold_pulse;
		logic               double_click_pulse;
		logic               click_pulse;
		logic               release_pulse;
		logic               push_pulse;
		logic               pressed_level;
		logic               sampled;
	} result_t;

endpackage

// ===== design/bchd_cfg.sv =====
// Configuration register file for the button click and hold detector.
module bchd_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            we,
	input  logic [bchd_pkg::CFG_IDX_W-1:0]  index,
	input  logic [bchd_pkg::CFG_DATA_W-1:0] wdata,
	output bchd_pkg::cfg_t                  cfg
);

	bchd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.block_enabled      <= 1'b1;
			cfg_q.invert_input       <= 1'b0;
			cfg_q.sample_interval_ms <= bchd_pkg::RST_SAMPLE_INTERVAL;
			cfg_q.min_press_ms       <= bchd_pkg::RST_MIN_PRESS;
			cfg_q.min_gap_ms         <= bchd_pkg::RST_MIN_GAP;
			cfg_q.double_span_ms     <= bchd_pkg::RST_DOUBLE_SPAN;
			cfg_q.hold_interval_ms   <= bchd_pkg::RST_HOLD_INTERVAL;
		end else if (we) begin
			case (index)
				bchd_pkg::REG_BLOCK_ENABLED:   cfg_q.block_enabled      <= wdata[0];
				bchd_pkg::REG_INVERT_INPUT:    cfg_q.invert_input       <= wdata[0];
				bchd_pkg::REG_SAMPLE_INTERVAL: cfg_q.sample_interval_ms <= wdata;
				bchd_pkg::REG_MIN_PRESS:       cfg_q.min_press_ms       <= wdata;
				bchd_pkg::REG_MIN_GAP:         cfg_q.min_gap_ms         <= wdata;
				bchd_pkg::REG_DOUBLE_SPAN:     cfg_q.double_span_ms     <= wdata;
				bchd_pkg::REG_HOLD_INTERVAL:   cfg_q.hold_interval_ms   <= wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/bchd_core.sv =====
// Per-tick timing state and event decode of the button click and hold detector.
module bchd_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic                           pin,
	input  bchd_pkg::cfg_t                 cfg,
	output logic [bchd_pkg::COUNT_W-1:0]   count_cur,
	output bchd_pkg::result_t              res
);

	localparam int unsigned TW = bchd_pkg::TIME_W;

	logic [TW-1:0] now_q, last_sample_q, press_start_q, release_start_q;
	logic [TW-1:0] prior_press_q, prior_release_q, hold_mark_q;
	logic          level_q, click_wait_q;
	logic [bchd_pkg::COUNT_W-1:0] count_q;

	logic [TW-1:0] smp_int, min_press, min_gap, span, hold_int;
	logic [TW-1:0] hold_dt, rel_start_n, plen, gap, prior_len;
	logic          do_sample, lvl, push, rel, hold, wait_mid, clk_ev, dbl;
	logic          plen_ok, prior_ok;

	always_comb begin
		smp_int   = {{(TW-bchd_pkg::CFG_DATA_W){1'b0}}, cfg.sample_interval_ms};
		min_press = {{(TW-bchd_pkg::CFG_DATA_W){1'b0}}, cfg.min_press_ms};
		min_gap   = {{(TW-bchd_pkg::CFG_DATA_W){1'b0}}, cfg.min_gap_ms};
		span      = {{(TW-bchd_pkg::CFG_DATA_W){1'b0}}, cfg.double_span_ms};
		hold_int  = {{(TW-bchd_pkg::CFG_DATA_W){1'b0}}, cfg.hold_interval_ms};

		do_sample = cfg.block_enabled && ((now_q - last_sample_q) >= smp_int);
		lvl       = pin ^ cfg.invert_input;
		push      = do_sample && lvl && !level_q;
		rel       = do_sample && !lvl && level_q;

		// a push restarts the hold mark at now, so its distance is zero
		hold_dt   = push ? '0 : (now_q - hold_mark_q);
		hold      = do_sample && lvl && (hold_dt >= hold_int);

		wait_mid    = push ? 1'b0 : (rel ? 1'b1 : click_wait_q);
		rel_start_n = rel ? now_q : release_start_q;
		plen        = rel_start_n - press_start_q;
		gap         = now_q - rel_start_n;
		plen_ok     = (plen >= min_press) && (plen < hold_int);
		clk_ev      = do_sample && wait_mid && plen_ok && (gap >= min_gap);

		prior_len = prior_release_q - prior_press_q;
		prior_ok  = (prior_len >= min_press) && (prior_len < hold_int);
		dbl       = clk_ev && prior_ok
		            && ((press_start_q - prior_release_q) >= min_gap)
		            && ((now_q - prior_press_q) <= span);

		res.sampled            = do_sample;
		res.pressed_level      = do_sample ? lvl : level_q;
		res.push_pulse         = push;
		res.release_pulse      = rel;
		res.click_pulse        = clk_ev;
		res.double_click_pulse = dbl;
		res.hold_pulse         = hold;
		res.click_total        = count_q + {{(bchd_pkg::COUNT_W-1){1'b0}}, clk_ev};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q           <= '0;
			last_sample_q   <= '0;
			press_start_q   <= '0;
			release_start_q <= '0;
			prior_press_q   <= '0;
			prior_release_q <= '0;
			hold_mark_q     <= '0;
			level_q         <= 1'b0;
			click_wait_q    <= 1'b0;
			count_q         <= '0;
		end else if (step) begin
			now_q <= now_q + {{(TW-1){1'b0}}, 1'b1};
			if (do_sample) begin
				last_sample_q <= now_q;
				level_q       <= lvl;
				click_wait_q  <= clk_ev ? 1'b0 : wait_mid;
			end
			if (push) begin
				prior_press_q   <= press_start_q;
				prior_release_q <= release_start_q;
				press_start_q   <= now_q;
			end
			if (push || hold)
				hold_mark_q <= now_q;
			if (rel)
				release_start_q <= now_q;
			count_q <= res.click_total;
		end
	end

	assign count_cur = count_q;

endmodule

// ===== design/button_click_hold_detector.sv =====
// Top level of the button click, double click and hold detector.
//
// Usage: one request on the s_ channel per millisecond tick, carrying the raw pin level
// in s_tdata[0]. Each request yields exactly one result request on the m_ channel with
// the sample flag, stored level, push / release / click / double click / hold pulses
// and the 16-bit wrapping click total. Time is counted in requests, not clock cycles,
// so the source sets the tick rate and the block may run from any faster clock.
// Path: a request is held in an input register, then the decode logic feeds the result
// register, which drives m_tvalid and m_tdata.
// Throughput: one request per cycle while the output is not stalled; the decode is a single
// pass of subtracts and compares on the 32-bit timestamps between the two registers.
// Stall: while m_tready is low the result register holds and the input register fills;
// s_tready drops only when both are occupied, and nothing is lost or repeated.
// Reset (arst_n low): time, timestamps, level and click total clear, configuration
// returns to enabled, no inversion, 5 / 40 / 40 / 500 / 500 ms.
// Configuration: cfg_we with cfg_index and cfg_wdata writes one register per edge;
// it is meant to be written while no request is in flight.
module button_click_hold_detector (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	// tick input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] pin_level, [7:1] zero
	// result output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // [0] sampled, [1] pressed_level, [2] push_pulse,
	                               // [3] release_pulse, [4] click_pulse,
	                               // [5] double_click_pulse, [6] hold_pulse,
	                               // [22:7] click_total, [23] zero
);

	bchd_pkg::cfg_t    cfg;
	bchd_pkg::result_t res, res_q;
	logic [bchd_pkg::COUNT_W-1:0] count_cur;

	logic valid_s1, pin_s1;
	logic out_valid_q;
	logic step;   // input register moves into the result register this edge

	assign step     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || step;

	bchd_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	bchd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.pin       (pin_s1),
		.cfg       (cfg),
		.count_cur (count_cur),
		.res       (res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			pin_s1 <= s_tdata[0];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (step)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step)
			res_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, res_q};

`ifndef NO_ASSERTIONS
	// a full input register with a stalled result register must refuse new ticks
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !m_tready |-> !s_tready)
		else $error("input accepted while both stages are blocked");

	// push and release cannot happen in one tick
	a_edge_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> !(res.push_pulse && res.release_pulse))
		else $error("push and release in the same tick");

	// disabled block never samples
	a_disabled_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		step && !cfg.block_enabled |-> !res.sampled && !res.click_pulse)
		else $error("sample taken while disabled");

	// click total advances by exactly one per click
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> count_cur == $past(count_cur)
			+ {{(bchd_pkg::COUNT_W-1){1'b0}}, $past(res.click_pulse)})
		else $error("click total out of step with click pulses");
`endif

endmodule
